// ===== sv/swrm_pkg.sv =====
// shared types and constants for the stack with remove-minimum
package swrm_pkg;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned IO_PAY_W  = 32;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMMIN = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_COMPACT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_RD,
    SRC_MIN
  } out_src_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  typedef struct packed {
    logic     out_load;
    logic     out_ok;
    out_src_e out_src;
    cnt_op_e  cnt_op;
    logic     push_wr;
    logic     pop_rd;
    logic     scan_start;
    logic     scan_step;
    logic     compact_step;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic out_free;
    logic idx_zero;
    logic idx_last;
  } status_t;

endpackage

// ===== sv/swrm_ctrl.sv =====
// controller state machine sequencing push, pop, remove-minimum and clear
module swrm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       action_i,
  input  swrm_pkg::status_t status_i,
  output swrm_pkg::cmd_t   cmd_o
);

  swrm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swrm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.out_src = swrm_pkg::SRC_ZERO;
    cmd_o.cnt_op  = swrm_pkg::CNT_HOLD;
    in_stall_o = 1'b1;
    unique case (state_q)
      swrm_pkg::ST_IDLE: begin
        in_stall_o = !status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          unique case (swrm_pkg::action_e'(action_i))
            swrm_pkg::ACT_PUSH: begin
              cmd_o.out_load = 1'b1;
              if (!status_i.full) begin
                cmd_o.push_wr = 1'b1;
                cmd_o.cnt_op  = swrm_pkg::CNT_INC;
                cmd_o.out_ok  = 1'b1;
              end
            end
            swrm_pkg::ACT_POP: begin
              if (status_i.empty) begin
                cmd_o.out_load = 1'b1;
              end else begin
                cmd_o.pop_rd = 1'b1;
                cmd_o.cnt_op = swrm_pkg::CNT_DEC;
                state_d      = swrm_pkg::ST_POP;
              end
            end
            swrm_pkg::ACT_REMMIN: begin
              if (status_i.empty) begin
                cmd_o.out_load = 1'b1;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = swrm_pkg::ST_SCAN;
              end
            end
            swrm_pkg::ACT_CLEAR: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_ok   = 1'b1;
              cmd_o.cnt_op   = swrm_pkg::CNT_CLR;
            end
            default: ;
          endcase
        end
      end
      swrm_pkg::ST_POP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ok   = 1'b1;
          cmd_o.out_src  = swrm_pkg::SRC_RD;
          state_d        = swrm_pkg::ST_IDLE;
        end
      end
      swrm_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.idx_zero) begin
          state_d = swrm_pkg::ST_COMPACT;
        end
      end
      swrm_pkg::ST_COMPACT: begin
        cmd_o.compact_step = 1'b1;
        if (status_i.idx_last) begin
          state_d = swrm_pkg::ST_DONE;
        end
      end
      swrm_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ok   = 1'b1;
          cmd_o.out_src  = swrm_pkg::SRC_MIN;
          state_d        = swrm_pkg::ST_IDLE;
        end
      end
      default: state_d = swrm_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/swrm_dpath.sv =====
// datapath: record memory, fill count, scan and compaction pointers, result register
module swrm_dpath #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned CW           = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swrm_pkg::cmd_t                cmd_i,
  output swrm_pkg::status_t             status_o,
  input  logic [swrm_pkg::KEY_W-1:0]    key_i,
  input  logic [swrm_pkg::IO_PAY_W-1:0] payload_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          ok_o,
  output logic [swrm_pkg::KEY_W-1:0]    key_o,
  output logic [swrm_pkg::IO_PAY_W-1:0] payload_o,
  output logic [CW-1:0]                 count_o,
  output logic                          is_empty_o,
  output logic                          is_full_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = (PAYLOAD_BITS < swrm_pkg::IO_PAY_W) ?
                               PAYLOAD_BITS : swrm_pkg::IO_PAY_W;
  localparam int unsigned EW = swrm_pkg::KEY_W + PW;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_q;

  logic [CW-1:0] cnt_q, cnt_d, cnt_m1, wr_q, wr_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [swrm_pkg::KEY_W-1:0] min_key_q, min_key_d;
  logic [PW-1:0] min_pay_q, min_pay_d;
  logic first_q, first_d;

  logic          re, we;
  logic [AW-1:0] ra, wa;
  logic [EW-1:0] wd;
  logic [swrm_pkg::KEY_W-1:0] rd_key;
  logic [PW-1:0] rd_pay;
  logic          keep;

  logic out_valid_q, out_free;
  logic ok_q, empty_q, full_q;
  logic [swrm_pkg::KEY_W-1:0] key_q;
  logic [swrm_pkg::IO_PAY_W-1:0] pay_q, pay_sel;
  logic [swrm_pkg::KEY_W-1:0] key_sel;
  logic [CW-1:0] count_q;

  assign cnt_m1 = cnt_q - CW'(1);
  assign rd_key = rd_data_q[EW-1:PW];
  assign rd_pay = rd_data_q[PW-1:0];
  assign keep   = (rd_key != min_key_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.empty    = (cnt_q == '0);
  assign status_o.full     = (cnt_q >= DEPTH_C);
  assign status_o.out_free = out_free;
  assign status_o.idx_zero = (idx_q == '0);
  assign status_o.idx_last = (idx_q == cnt_m1[AW-1:0]);

  // memory port addressing
  always_comb begin
    re = 1'b0;
    ra = idx_q;
    we = 1'b0;
    wa = cnt_q[AW-1:0];
    wd = {key_i, payload_i[PW-1:0]};
    if (cmd_i.pop_rd || cmd_i.scan_start) begin
      re = 1'b1;
      ra = cnt_m1[AW-1:0];
    end else if (cmd_i.scan_step) begin
      re = 1'b1;
      ra = status_o.idx_zero ? '0 : idx_q - AW'(1);
    end else if (cmd_i.compact_step && !status_o.idx_last) begin
      re = 1'b1;
      ra = idx_q + AW'(1);
    end
    if (cmd_i.push_wr) begin
      we = 1'b1;
    end else if (cmd_i.compact_step && keep) begin
      we = 1'b1;
      wa = wr_q[AW-1:0];
      wd = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[ra];
    end
  end

  // scan and compaction bookkeeping
  always_comb begin
    idx_d     = re ? ra : idx_q;
    min_key_d = min_key_q;
    min_pay_d = min_pay_q;
    first_d   = first_q;
    wr_d      = wr_q;
    if (cmd_i.scan_start) begin
      first_d = 1'b1;
      wr_d    = '0;
    end
    if (cmd_i.scan_step) begin
      first_d = 1'b0;
      if (first_q || (rd_key < min_key_q)) begin
        min_key_d = rd_key;
        min_pay_d = rd_pay;
      end
    end
    if (cmd_i.compact_step && keep) begin
      wr_d = wr_q + CW'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.compact_step && status_o.idx_last) begin
      cnt_d = wr_d;
    end else begin
      unique case (cmd_i.cnt_op)
        swrm_pkg::CNT_HOLD: cnt_d = cnt_q;
        swrm_pkg::CNT_INC:  cnt_d = cnt_q + CW'(1);
        swrm_pkg::CNT_DEC:  cnt_d = cnt_m1;
        swrm_pkg::CNT_CLR:  cnt_d = '0;
        default:            cnt_d = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    wr_q      <= wr_d;
    min_key_q <= min_key_d;
    min_pay_q <= min_pay_d;
  end

  // result register
  always_comb begin
    key_sel = '0;
    pay_sel = '0;
    unique case (cmd_i.out_src)
      swrm_pkg::SRC_ZERO: ;
      swrm_pkg::SRC_RD: begin
        key_sel         = rd_key;
        pay_sel[PW-1:0] = rd_pay;
      end
      swrm_pkg::SRC_MIN: begin
        key_sel         = min_key_q;
        pay_sel[PW-1:0] = min_pay_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ok_q    <= cmd_i.out_ok;
      key_q   <= key_sel;
      pay_q   <= pay_sel;
      count_q <= cnt_d;
      empty_q <= (cnt_d == '0);
      full_q  <= (cnt_d >= DEPTH_C);
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign key_o       = key_q;
  assign payload_o   = pay_q;
  assign count_o     = count_q;
  assign is_empty_o  = empty_q;
  assign is_full_o   = full_q;

endmodule

// ===== sv/stack_with_remove_min_top.sv =====
// top level of the record stack with push, pop, remove-minimum and clear
// usage:
//   input channel carries action, key and payload words; output channel carries
//   ok, key_out, payload_out, count, is_empty and is_full words
//   both channels use valid/stall, a word moves when valid is high and stall low
//   one result word for every input word, in order
// action sequencing:
//   push, clear and failed actions: result registered at the accepting edge
//   pop: one registered read of the record memory, then the result register
//   remove-minimum on n records: a top-down scan reading one entry a cycle,
//   then a compaction pass reading one entry a cycle and rewriting those kept
//   one action is in progress at a time; the next word is taken once it is done
// reset: fill count cleared, stack empty, no result pending; no memory clearing pass
// receiver stall: the result holds in the output register; a finished action waits
//   there and new input words stall until the output register can be reloaded
module stack_with_remove_min_top #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       action_i,
  input  logic [swrm_pkg::KEY_W-1:0]       key_in_i,
  input  logic [swrm_pkg::IO_PAY_W-1:0]    payload_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ok_o,
  output logic [swrm_pkg::KEY_W-1:0]       key_out_o,
  output logic [swrm_pkg::IO_PAY_W-1:0]    payload_out_o,
  output logic [$clog2(DEPTH + 1)-1:0]     count_o,
  output logic                             is_empty_o,
  output logic                             is_full_o
);

  swrm_pkg::cmd_t    cmd;
  swrm_pkg::status_t status;

  swrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swrm_dpath #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .CW           ($clog2(DEPTH + 1))
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .key_i       (key_in_i),
    .payload_i   (payload_in_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .ok_o        (ok_o),
    .key_o       (key_out_o),
    .payload_o   (payload_out_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o)
  );

endmodule
